FILE: rtl/core/bunp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bunp_pkg
// Shared types, codes, character constants and the digit decode function
// for the bounded unsigned number parser.
// ----------------------------------------------------------------------------
package bunp_pkg;

    localparam int DEF_VALUE_WIDTH       = 64;
    localparam int DEF_MAX_STRING_LENGTH = 65535;
    localparam int BYTE_W                = 8;
    localparam int STOP_W                = 16;
    localparam int DIGIT_W               = 5;

    // base_select codes that are honored
    localparam logic [BYTE_W-1:0] SEL_OCT = 8'd8;
    localparam logic [BYTE_W-1:0] SEL_DEC = 8'd10;
    localparam logic [BYTE_W-1:0] SEL_HEX = 8'd16;

    // characters
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_X_LO  = 8'h78;
    localparam logic [BYTE_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [BYTE_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_F_LO  = 8'h66;
    localparam logic [BYTE_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_F_UP  = 8'h46;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'h1F;

    typedef enum logic [2:0] {
        PH_WS   = 3'd0,
        PH_SIGN = 3'd1,
        PH_ZERO = 3'd2,
        PH_DIG  = 3'd3,
        PH_DONE = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        AB_DEC = 2'd0,
        AB_OCT = 2'd1,
        AB_HEX = 2'd2
    } t_base;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              last_byte;
    } t_item;

    typedef struct packed {
        logic bad;
        logic ovf;
    } t_digit_status;

    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [STOP_W-1:0] stop;
    } t_result_flags;

    // value of a hex/dec digit character, DIGIT_NONE otherwise
    function automatic logic [DIGIT_W-1:0] digit_value(input logic [BYTE_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = DIGIT_W'(c - CH_ZERO);
        end else if (c >= CH_A_LO && c <= CH_F_LO) begin
            d = DIGIT_W'(c - CH_A_LO) + 5'd10;
        end else if (c >= CH_A_UP && c <= CH_F_UP) begin
            d = DIGIT_W'(c - CH_A_UP) + 5'd10;
        end
        return d;
    endfunction

    function automatic logic [DIGIT_W-1:0] base_radix(input t_base b);
        logic [DIGIT_W-1:0] r;
        case (b)
            AB_OCT:  r = 5'd8;
            AB_HEX:  r = 5'd16;
            default: r = 5'd10;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/bunp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bunp_in_if / bunp_out_if
// Valid/ready channels for string bytes in and parse results out.
// ----------------------------------------------------------------------------
interface bunp_in_if;
    logic                       valid;
    logic                       ready;
    logic [bunp_pkg::BYTE_W-1:0] data_byte;
    logic                       has_byte;
    logic                       last_byte;

    modport source (output valid, output data_byte, output has_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last_byte,
                    output ready);
endinterface

interface bunp_out_if #(
    parameter int VALUE_WIDTH = bunp_pkg::DEF_VALUE_WIDTH
);
    logic                        valid;
    logic                        ready;
    logic [VALUE_WIDTH-1:0]      parsed_value;
    logic [bunp_pkg::STOP_W-1:0] stop_offset;
    logic                        range_error;

    modport source (output valid, output parsed_value, output stop_offset,
                    output range_error, input ready);
    modport sink   (input valid, input parsed_value, input stop_offset,
                    input range_error, output ready);
endinterface

FILE: rtl/core/bounded_unsigned_number_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_unsigned_number_parser
// Parses a length-bounded ASCII string, one byte per transfer, into an
// unsigned value with stop offset and range error.
// ----------------------------------------------------------------------------
// result: the result register loads as the last byte leaves the byte register
// throughput: one byte per cycle, set by the combinational digit step (one
//   shift/times-ten add and limit compare) between the byte register and the
//   parse state; a last byte waits while a result is still waiting
// reset: synchronous, active low; clears the parse state, both stage valids
//   and base_select (automatic base); no clearing pass
// ----------------------------------------------------------------------------
module bounded_unsigned_number_parser #(
    parameter int VALUE_WIDTH       = bunp_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_STRING_LENGTH = bunp_pkg::DEF_MAX_STRING_LENGTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bunp_pkg::BYTE_W-1:0] i_cfg_wdata,
    bunp_in_if.sink                     i_in,
    bunp_out_if.source                  o_out
);

    // configuration
    logic [bunp_pkg::BYTE_W-1:0] r_base_select;

    // byte register
    logic                    r_in_valid;
    bunp_pkg::t_item         r_in;

    // result register, the sign is applied on the way out
    logic                    r_out_valid;
    logic [VALUE_WIDTH-1:0]  r_out_acc;
    bunp_pkg::t_result_flags r_out_flags;

    logic                    fire;
    logic [VALUE_WIDTH-1:0]  step_acc;
    bunp_pkg::t_result_flags step_flags;

    // only a string end needs room in the result register
    assign fire       = r_in_valid && (!r_in.last_byte || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_select <= '0;
        end else if (i_cfg_we) begin
            r_base_select <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // payload loads on an input transfer only
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.data_byte <= i_in.data_byte;
            r_in.has_byte  <= i_in.has_byte;
            r_in.last_byte <= i_in.last_byte;
        end
    end

    bunp_parse_fsm #(
        .VALUE_WIDTH       (VALUE_WIDTH),
        .MAX_STRING_LENGTH (MAX_STRING_LENGTH)
    ) u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (r_in),
        .i_base_select (r_base_select),
        .o_acc         (step_acc),
        .o_flags       (step_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in.last_byte) begin
            r_out_acc   <= step_acc;
            r_out_flags <= step_flags;
        end
    end

    // overflow saturates and is never negated; minus wraps modulo 2^width
    assign o_out.valid        = r_out_valid;
    assign o_out.parsed_value = r_out_flags.ovf ? {VALUE_WIDTH{1'b1}}
                              : (r_out_flags.neg ? (~r_out_acc + 1'b1) : r_out_acc);
    assign o_out.stop_offset  = r_out_flags.stop;
    assign o_out.range_error  = r_out_flags.ovf;

    // an empty byte register always takes a transfer
    a_free_stage_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("byte register empty but input not ready");

    // a string end never overwrites a result that is still waiting
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.last_byte && r_out_valid && !o_out.ready) |-> !fire)
        else $error("string end advanced over a waiting result");

    // a waiting result survives a stalled cycle with its value
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_acc)
                                           && $stable(r_out_flags)))
        else $error("waiting result lost or changed");

    // range error always comes with a saturated value
    a_sat_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.range_error) |-> (&o_out.parsed_value))
        else $error("range error without saturated value");

endmodule

FILE: rtl/core/bunp_digit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bunp_digit_unit
// Decodes one digit in the base in effect, checks for overflow and forms
// the next accumulator value.
// ----------------------------------------------------------------------------
module bunp_digit_unit #(
    parameter int VALUE_WIDTH = bunp_pkg::DEF_VALUE_WIDTH
) (
    input  logic [VALUE_WIDTH-1:0]       i_acc,
    input  bunp_pkg::t_base              i_base,
    input  logic [bunp_pkg::BYTE_W-1:0]  i_char,
    output logic [VALUE_WIDTH-1:0]       o_acc_next,
    output bunp_pkg::t_digit_status      o_status
);

    localparam logic [VALUE_WIDTH-1:0] VMAX    = '1;
    localparam logic [VALUE_WIDTH-1:0] LIM_DEC = VALUE_WIDTH'(VMAX / 10);
    localparam logic [3:0]             REM_DEC = 4'(VMAX % 10);
    localparam logic [VALUE_WIDTH-1:0] LIM_OCT = VMAX >> 3;
    localparam logic [VALUE_WIDTH-1:0] LIM_HEX = VMAX >> 4;
    localparam logic [3:0]             REM_OCT = 4'd7;
    localparam logic [3:0]             REM_HEX = 4'd15;

    logic [bunp_pkg::DIGIT_W-1:0] dv;
    logic [3:0]                   d;
    logic [VALUE_WIDTH-1:0]       lim;
    logic [3:0]                   rem;
    logic [VALUE_WIDTH-1:0]       d_ext;

    assign dv    = bunp_pkg::digit_value(i_char);
    assign d     = dv[3:0];
    assign d_ext = VALUE_WIDTH'(d);

    always_comb begin
        case (i_base)
            bunp_pkg::AB_OCT: begin
                lim        = LIM_OCT;
                rem        = REM_OCT;
                o_acc_next = {i_acc[VALUE_WIDTH-4:0], 3'b000} + d_ext;
            end
            bunp_pkg::AB_HEX: begin
                lim        = LIM_HEX;
                rem        = REM_HEX;
                o_acc_next = {i_acc[VALUE_WIDTH-5:0], 4'b0000} + d_ext;
            end
            default: begin
                lim        = LIM_DEC;
                rem        = REM_DEC;
                // times ten as 8x + 2x
                o_acc_next = {i_acc[VALUE_WIDTH-4:0], 3'b000}
                           + {i_acc[VALUE_WIDTH-2:0], 1'b0} + d_ext;
            end
        endcase
    end

    assign o_status.bad = (dv >= bunp_pkg::base_radix(i_base));
    assign o_status.ovf = (i_acc > lim) || ((i_acc == lim) && (d > rem));

endmodule

FILE: rtl/core/bunp_parse_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bunp_parse_fsm
// Per-string parse state: phase, position, sign, base, accumulator, stop
// and overflow; steps once per byte and clears after the last one.
// ----------------------------------------------------------------------------
module bunp_parse_fsm #(
    parameter int VALUE_WIDTH       = bunp_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_STRING_LENGTH = bunp_pkg::DEF_MAX_STRING_LENGTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  bunp_pkg::t_item             i_item,
    input  logic [bunp_pkg::BYTE_W-1:0] i_base_select,
    output logic [VALUE_WIDTH-1:0]      o_acc,
    output bunp_pkg::t_result_flags     o_flags
);

    localparam int               POS_W   = $clog2(MAX_STRING_LENGTH + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_STRING_LENGTH);

    bunp_pkg::t_phase              r_phase, n_phase;
    bunp_pkg::t_base               r_base, n_base;
    logic [POS_W-1:0]              r_pos, n_pos;
    logic [VALUE_WIDTH-1:0]        r_acc, n_acc;
    logic                          r_neg, n_neg;
    logic [bunp_pkg::STOP_W-1:0]   r_fstop, n_fstop;
    logic                          r_ovf, n_ovf;

    logic [POS_W+bunp_pkg::STOP_W-1:0] pos_ext;
    logic [POS_W+bunp_pkg::STOP_W-1:0] npos_ext;
    logic [bunp_pkg::STOP_W-1:0]       pos16;
    logic [bunp_pkg::BYTE_W-1:0]       c;
    logic                              is_dec;
    logic                              first;
    logic                              take;
    bunp_pkg::t_base                   first_base;
    bunp_pkg::t_base                   zero_base;
    bunp_pkg::t_base                   take_base;
    logic [VALUE_WIDTH-1:0]            acc_next;
    bunp_pkg::t_digit_status           dstat;

    assign c        = i_item.data_byte;
    assign is_dec   = (c >= bunp_pkg::CH_ZERO) && (c <= bunp_pkg::CH_NINE);
    assign pos_ext  = {{bunp_pkg::STOP_W{1'b0}}, r_pos};
    assign npos_ext = {{bunp_pkg::STOP_W{1'b0}}, n_pos};
    assign pos16    = pos_ext[bunp_pkg::STOP_W-1:0];

    // base is sampled at the first character after blanks and sign
    always_comb begin
        if (i_base_select == bunp_pkg::SEL_HEX) begin
            first_base = bunp_pkg::AB_HEX;
        end else if (i_base_select == bunp_pkg::SEL_OCT) begin
            first_base = bunp_pkg::AB_OCT;
        end else begin
            first_base = bunp_pkg::AB_DEC;
        end
    end

    // leading zero in auto mode turns decimal into octal
    assign zero_base = (r_base == bunp_pkg::AB_DEC) ? bunp_pkg::AB_OCT : r_base;

    always_comb begin
        case (r_phase)
            bunp_pkg::PH_WS, bunp_pkg::PH_SIGN: take_base = first_base;
            bunp_pkg::PH_ZERO:                  take_base = zero_base;
            default:                            take_base = r_base;
        endcase
    end

    bunp_digit_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_digit (
        .i_acc      (r_acc),
        .i_base     (take_base),
        .i_char     (c),
        .o_acc_next (acc_next),
        .o_status   (dstat)
    );

    always_comb begin
        n_phase = r_phase;
        n_base  = r_base;
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_fstop = r_fstop;
        n_ovf   = r_ovf;
        first   = 1'b0;
        take    = 1'b0;

        if (i_item.has_byte) begin
            case (r_phase)
                bunp_pkg::PH_WS: begin
                    if (c == bunp_pkg::CH_SPACE || c == bunp_pkg::CH_TAB) begin
                        n_phase = bunp_pkg::PH_WS;
                    end else if (c == bunp_pkg::CH_MINUS || c == bunp_pkg::CH_PLUS) begin
                        n_neg   = (c == bunp_pkg::CH_MINUS);
                        n_fstop = pos16;
                        n_phase = bunp_pkg::PH_SIGN;
                    end else begin
                        first = 1'b1;
                    end
                end
                bunp_pkg::PH_SIGN: begin
                    first = 1'b1;
                end
                bunp_pkg::PH_ZERO: begin
                    n_phase = bunp_pkg::PH_DIG;
                    if (c == bunp_pkg::CH_X_LO || c == bunp_pkg::CH_X_UP) begin
                        n_base = bunp_pkg::AB_HEX;
                    end else begin
                        n_base = zero_base;
                        take   = 1'b1;
                    end
                end
                bunp_pkg::PH_DIG: begin
                    take = 1'b1;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            if (first) begin
                n_base = first_base;
                if (i_base_select == bunp_pkg::SEL_HEX) begin
                    // optional 0x prefix in hex mode
                    n_phase = (c == bunp_pkg::CH_ZERO) ? bunp_pkg::PH_ZERO : bunp_pkg::PH_DIG;
                    take    = (c != bunp_pkg::CH_ZERO);
                end else if (!is_dec) begin
                    n_fstop = pos16;
                    n_phase = bunp_pkg::PH_DONE;
                end else if (i_base_select != bunp_pkg::SEL_OCT &&
                             i_base_select != bunp_pkg::SEL_DEC &&
                             c == bunp_pkg::CH_ZERO) begin
                    n_phase = bunp_pkg::PH_ZERO;
                end else begin
                    n_phase = bunp_pkg::PH_DIG;
                    take    = 1'b1;
                end
            end

            if (take) begin
                if (dstat.bad) begin
                    n_fstop = pos16;
                    n_phase = bunp_pkg::PH_DONE;
                end else if (dstat.ovf) begin
                    n_ovf   = 1'b1;
                    n_fstop = pos16;
                    n_phase = bunp_pkg::PH_DONE;
                end else begin
                    n_acc = acc_next;
                end
            end

            n_pos = (r_pos == MAX_POS) ? r_pos : r_pos + 1'b1;
        end
    end

    // result of this step, used when the item ends the string
    assign o_acc       = n_acc;
    assign o_flags.neg = n_neg;
    assign o_flags.ovf = n_ovf;
    assign o_flags.stop = (n_phase == bunp_pkg::PH_WS || n_phase == bunp_pkg::PH_ZERO ||
                           n_phase == bunp_pkg::PH_DIG)
                        ? npos_ext[bunp_pkg::STOP_W-1:0] : n_fstop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last_byte)) begin
            r_phase <= bunp_pkg::PH_WS;
            r_base  <= bunp_pkg::AB_DEC;
            r_pos   <= '0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_fstop <= '0;
            r_ovf   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_base  <= n_base;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_fstop <= n_fstop;
            r_ovf   <= n_ovf;
        end
    end

endmodule
